### hw/rtl/signed_floor_div_mod_assert.svh
// assertion macros shared by the signed floor divide/modulo rtl
// expects clk and rst (synchronous, active high) in the using module
`ifndef SIGNED_FLOOR_DIV_MOD_ASSERT_SVH
`define SIGNED_FLOOR_DIV_MOD_ASSERT_SVH

// same-cycle implication
`define SFDM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdm assertion failed");

// next-cycle implication
`define SFDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdm assertion failed");

`endif

### hw/rtl/sfdm_pkg.sv
// shared types and constants for the signed floor divide/modulo block
// no dependencies
package sfdm_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_QUOT = 1'b0,
    KIND_MOD  = 1'b1
  } kind_t;

  // classified operation handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic              dbz;
    logic              num_neg;
    logic              den_neg;
    logic [DATA_W-1:0] un;
    logic [DATA_W-1:0] ud;
  } op_t;

endpackage

### hw/rtl/sfdm_front.sv
// input stage: takes a beat, flags zero divisor, splits signs and magnitudes
// depends on sfdm_pkg
module sfdm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sfdm_pkg::kind_t           in_kind,
  input  logic [sfdm_pkg::DATA_W-1:0] in_dividend,
  input  logic [sfdm_pkg::DATA_W-1:0] in_divisor,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sfdm_pkg::op_t             out_op
);
  import sfdm_pkg::*;

  logic valid;
  op_t  op;
  op_t  op_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_op    = op;

  always_comb begin
    op_next.kind    = in_kind;
    op_next.dbz     = (in_divisor == '0);
    op_next.num_neg = in_dividend[DATA_W-1];
    op_next.den_neg = in_divisor[DATA_W-1];
    op_next.un      = in_dividend[DATA_W-1] ? ('0 - in_dividend) : in_dividend;
    op_next.ud      = in_divisor[DATA_W-1] ? ('0 - in_divisor) : in_divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= op_next;
    end
  end

endmodule

### hw/rtl/sfdm_queue.sv
// small fifo between classifier and divider pipeline
// depends on sfdm_pkg
module sfdm_queue #(
  parameter int unsigned DEPTH = sfdm_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfdm_pkg::op_t in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output sfdm_pkg::op_t out_op
);
  import sfdm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_op    = mem[head];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= ptr_inc(tail);
      if (pop)  head <= ptr_inc(head);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= in_op;
    end
  end

endmodule

### hw/rtl/sfdm_back.sv
// divider pipeline: one restoring step per stage, then floor fix-up
// depends on sfdm_pkg and signed_floor_div_mod_assert.svh
`include "signed_floor_div_mod_assert.svh"
module sfdm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sfdm_pkg::op_t               in_op,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sfdm_pkg::DATA_W-1:0] out_value,
  output logic                        out_dbz
);
  import sfdm_pkg::*;

  localparam int unsigned STEPS = DATA_W;

  typedef struct packed {
    kind_t             kind;
    logic              dbz;
    logic              num_neg;
    logic              den_neg;
    logic [DATA_W-1:0] ud;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
  } stage_t;

  stage_t            st [STEPS+1];
  logic [STEPS:0]    vld;
  logic              adv;
  stage_t            init;
  logic [DATA_W-1:0] value_next;

  function automatic stage_t div_step(stage_t s);
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    stage_t          r;
    r     = s;
    trial = {s.rem, s.quo[DATA_W-1]};
    diff  = trial - {1'b0, s.ud};
    if (!diff[DATA_W]) begin
      r.rem = diff[DATA_W-1:0];
      r.quo = {s.quo[DATA_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DATA_W-1:0];
      r.quo = {s.quo[DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // whole pipeline moves together when the output slot frees up
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    init.kind    = in_op.kind;
    init.dbz     = in_op.dbz;
    init.num_neg = in_op.num_neg;
    init.den_neg = in_op.den_neg;
    init.ud      = in_op.ud;
    init.rem     = '0;
    init.quo     = in_op.un;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= init;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= div_step(st[k]);
      end
    end
  end

  // floor correction on magnitudes: quotient and remainder of |a| / |b|
  always_comb begin
    logic [DATA_W-1:0] uq;
    logic [DATA_W-1:0] ur;
    logic              differ;
    uq     = st[STEPS].quo;
    ur     = st[STEPS].rem;
    differ = st[STEPS].num_neg ^ st[STEPS].den_neg;
    if (st[STEPS].dbz) begin
      value_next = '0;
    end else if (st[STEPS].kind == KIND_QUOT) begin
      if (!differ) begin
        value_next = uq;
      end else if (ur != '0) begin
        value_next = ~uq;
      end else begin
        value_next = '0 - uq;
      end
    end else begin
      if (!differ) begin
        value_next = st[STEPS].num_neg ? ('0 - ur) : ur;
      end else if (ur == '0) begin
        value_next = '0;
      end else begin
        value_next = st[STEPS].den_neg ? (ur - st[STEPS].ud) : (st[STEPS].ud - ur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value <= value_next;
      out_dbz   <= st[STEPS].dbz;
    end
  end

  `SFDM_ASSERT_IMPLY(a_dbz_gives_zero, out_valid && out_dbz, out_value == '0)
  `SFDM_ASSERT_NEXT(a_last_stage_lands, adv && vld[STEPS], out_valid)
  `SFDM_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld))

endmodule

### hw/rtl/signed_floor_div_mod.sv
// signed 64-bit floor divide / floor modulo, stream in and stream out
// depends on sfdm_pkg, sfdm_front, sfdm_queue, sfdm_back
//
// usage:
//   slave side: one beat per operation; s_tdata = dividend [63:0],
//   divisor [127:64]; s_tuser = kind (0 floor quotient, 1 floor modulo)
//   master side: one beat per operation, in order; m_tdata = value,
//   m_tuser = divide_by_zero (value is then 0)
//   the quotient rounds toward minus infinity and the modulo takes the
//   divisor's sign; minimum over minus one wraps to minimum, modulo 0
// path from accepted beat to m_tvalid: classifier register, queue,
//   divider input register, 64 restoring steps, fix-up register
// throughput: one beat per cycle when not stalled; the 64-stage divider
//   pipeline takes one new operation every cycle it advances
// stall: the divider pipeline and output register freeze together while
//   m_tvalid is high and m_tready low; the queue and classifier keep
//   taking beats until they fill, then s_tready drops
// reset: rst (synchronous, active high) empties all stages; no state kept
module signed_floor_div_mod #(
  parameter int unsigned QUEUE_DEPTH = sfdm_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [2*sfdm_pkg::DATA_W-1:0] s_tdata,  // dividend, divisor
  input  logic                          s_tuser,  // kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sfdm_pkg::DATA_W-1:0]   m_tdata,  // value
  output logic                          m_tuser   // divide_by_zero
);
  import sfdm_pkg::*;

  logic  f_valid;
  logic  f_ready;
  op_t   f_op;
  logic  q_valid;
  logic  q_ready;
  op_t   q_op;
  kind_t kind;

  assign kind = kind_t'(s_tuser);

  // classify: zero divisor flag, operand signs, magnitudes
  sfdm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_kind     (kind),
    .in_dividend (s_tdata[DATA_W-1:0]),
    .in_divisor  (s_tdata[2*DATA_W-1:DATA_W]),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_op      (f_op)
  );

  // decouples the classifier from divider stalls
  sfdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_op    (q_op)
  );

  // pipelined divider with floor fix-up and output register
  sfdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_op     (q_op),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_dbz   (m_tuser)
  );

endmodule
